FILE: rtl/cfit_pkg.sv
// Shared widths, index tables, status codes and bundle types for the cubic fit block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package cfit_pkg;

    // Item layout
    localparam int NPT      = 4;
    localparam int COORD_W  = 32;
    localparam int IN_W     = 2 * NPT * COORD_W;
    localparam int COEF_W   = 64;
    localparam int OUT_W    = NPT * COEF_W;
    localparam int STAT_W   = 2;

    // Front-end arithmetic
    localparam int NPAIR    = 6;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PAIR_W   = 2 * COORD_W;
    localparam int SIG1_W   = COORD_W + 2;
    localparam int SIG2_W   = PAIR_W + 2;
    localparam int W_W      = 4 * COORD_W;
    localparam int DEN_W    = 6 * COORD_W;

    // Generic multiplier: 32-bit chunks, A up to 256 bits, B up to 64 bits
    localparam int MUL_CH   = 32;
    localparam int MUL_AW   = 256;
    localparam int MUL_BW   = 64;
    localparam int MUL_PW   = MUL_AW + MUL_BW;
    localparam int MUL_NA   = MUL_AW / MUL_CH;
    localparam int MUL_NB   = MUL_BW / MUL_CH;
    localparam int MUL_LAT  = 3;

    // Lane arithmetic
    localparam int TERM_W   = 7 * COORD_W;
    localparam int SUM_W    = TERM_W + 3;
    localparam int QUO_W    = COEF_W + 1;
    localparam int NUM_W    = SUM_W - 1 + QUO_W - 1;
    localparam int REM_W    = DEN_W + QUO_W;
    localparam int SHIFT_W  = 7;
    localparam int Q_SHIFT_BASE = 16;
    localparam int DEN_DLY  = 7;

    // Pipeline depths (registers, input register included)
    localparam int FRONT_DEPTH = 6;
    localparam int LANE_DEPTH  = 2 * MUL_LAT + 4 + 1 + QUO_W + 1;
    localparam int PIPE_DEPTH  = FRONT_DEPTH + LANE_DEPTH;

    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    // Pair p is (PAIR_J[p], PAIR_K[p]) with J < K
    localparam int PAIR_J [NPAIR] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_K [NPAIR] = '{1, 2, 3, 2, 3, 3};

    // For point i, the other three points a < b < c and their pairs
    localparam int OTH_A   [NPT] = '{1, 0, 0, 0};
    localparam int OTH_B   [NPT] = '{2, 2, 1, 1};
    localparam int OTH_C   [NPT] = '{3, 3, 3, 2};
    localparam int PAIR_AB [NPT] = '{3, 1, 0, 0};
    localparam int PAIR_AC [NPT] = '{4, 2, 2, 1};
    localparam int PAIR_BC [NPT] = '{5, 5, 4, 3};

    // Lane selector: power of x the lane produces
    localparam logic [1:0] PWR_CONST = 2'd0;
    localparam logic [1:0] PWR_LIN   = 2'd1;
    localparam logic [1:0] PWR_SQR   = 2'd2;
    localparam logic [1:0] PWR_CUBE  = 2'd3;

    typedef enum logic [STAT_W-1:0] {
        FIT_OK        = 2'd0,
        FIT_SINGULAR  = 2'd1,
        FIT_SATURATED = 2'd2
    } fit_status_t;

    // Per-point data shared by all lanes
    typedef struct packed {
        logic                     wneg;
        logic signed [SIG1_W-1:0] sig1;
        logic signed [SIG2_W-1:0] sig2;
        logic signed [PAIR_W-1:0] pab;
        logic signed [COORD_W-1:0] xc;
    } side_t;

    typedef struct packed {
        logic [W_W-1:0] w_mag;
        side_t          side;
    } lane_in_t;

    // Magnitude of a difference (never the most negative 33-bit value)
    function automatic logic [COORD_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] n;
        n = v[DIFF_W-1] ? -v : v;
        return n[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cfit_mul.sv
// Pipelined unsigned multiplier, 256 x 64 bits, built from 32 x 32 partial products.
// Depends on cfit_pkg. Registers: partial products, first adder level, product; advances on en.
`default_nettype none

module cfit_mul
    import cfit_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [MUL_AW-1:0] a,
    input  wire logic [MUL_BW-1:0] b,
    output logic      [MUL_PW-1:0] p
);

    logic [2*MUL_CH-1:0] pp_reg  [MUL_NA][MUL_NB];
    logic [MUL_PW-1:0]   vec     [MUL_NB][2];
    logic [MUL_PW-1:0]   sum_reg [MUL_NB];
    logic [MUL_PW-1:0]   p_reg;

    // Partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < MUL_NA; i++)
            begin
                for (int j = 0; j < MUL_NB; j++)
                begin
                    pp_reg[i][j] <= (2*MUL_CH)'(a[i*MUL_CH +: MUL_CH]) *
                                    (2*MUL_CH)'(b[j*MUL_CH +: MUL_CH]);
                end
            end
        end
    end

    // Even and odd chunks do not overlap: lay them side by side
    always_comb
    begin
        for (int j = 0; j < MUL_NB; j++)
        begin
            vec[j][0] = '0;
            vec[j][1] = '0;
            for (int i = 0; i < MUL_NA; i++)
            begin
                vec[j][i % 2][(i + j) * MUL_CH +: 2*MUL_CH] = pp_reg[i][j];
            end
        end
    end

    // Two adder levels
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < MUL_NB; j++)
            begin
                sum_reg[j] <= vec[j][0] + vec[j][1];
            end
            p_reg <= sum_reg[0] + sum_reg[1];
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

FILE: rtl/cfit_front.sv
// Shared front end: differences, pair products, per-point weights and the denominator.
// Depends on cfit_pkg and cfit_mul. Point data passes one multiplier, the denominator two in series.
`default_nettype none

module cfit_front
    import cfit_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [IN_W-1:0] pts,
    output lane_in_t             pnt [NPT],
    output logic                 sing,
    output logic [DEN_W-1:0]     den_mag,
    output logic                 den_neg
);

    logic signed [COORD_W-1:0] x_reg  [NPT];
    logic signed [COORD_W-1:0] y_reg  [NPT];
    logic signed [COORD_W-1:0] x2_reg [NPT];
    logic signed [COORD_W-1:0] y2_reg [NPT];
    logic signed [DIFF_W-1:0]  d_reg  [NPAIR];
    logic signed [PAIR_W-1:0]  pp_reg [NPAIR];
    logic                      eq2_reg;
    logic                      eq_next;

    logic [PAIR_W-1:0] e3_reg  [NPT];
    logic [PAIR_W-1:0] f3_reg  [NPT];
    side_t             side3_reg [NPT];
    logic [PAIR_W-1:0] gm3_reg [3];
    logic              dneg3_reg;
    logic              eq3_reg;

    side_t             side_dl_reg [MUL_LAT][NPT];
    logic [PAIR_W-1:0] g2_dl_reg   [MUL_LAT];
    logic              eq_dl_reg   [MUL_LAT];
    logic              dneg_dl_reg [2*MUL_LAT];

    logic [MUL_PW-1:0] w_p [NPT];
    logic [MUL_PW-1:0] h_p;
    logic [MUL_PW-1:0] den_p;

    // Input register and repeated abscissa check
    always_comb
    begin
        eq_next = 1'b0;
        for (int p = 0; p < NPAIR; p++)
        begin
            if (x_reg[PAIR_J[p]] == x_reg[PAIR_K[p]])
            begin
                eq_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NPT; i++)
            begin
                x_reg[i]  <= pts[2*i*COORD_W +: COORD_W];
                y_reg[i]  <= pts[(2*i+1)*COORD_W +: COORD_W];
                x2_reg[i] <= x_reg[i];
                y2_reg[i] <= y_reg[i];
            end
            for (int p = 0; p < NPAIR; p++)
            begin
                d_reg[p]  <= DIFF_W'(x_reg[PAIR_J[p]]) - DIFF_W'(x_reg[PAIR_K[p]]);
                pp_reg[p] <= PAIR_W'(x_reg[PAIR_J[p]]) * PAIR_W'(x_reg[PAIR_K[p]]);
            end
            eq2_reg <= eq_next;
        end
    end

    // Per-point factors, symmetric sums and denominator pieces
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NPT; i++)
            begin
                e3_reg[i] <= PAIR_W'(mag33(DIFF_W'(y2_reg[i]))) *
                             PAIR_W'(mag33(d_reg[PAIR_BC[i]]));
                f3_reg[i] <= PAIR_W'(mag33(d_reg[PAIR_AB[i]])) *
                             PAIR_W'(mag33(d_reg[PAIR_AC[i]]));
                side3_reg[i].wneg <= y2_reg[i][COORD_W-1] ^ d_reg[PAIR_AB[i]][DIFF_W-1] ^
                                     d_reg[PAIR_AC[i]][DIFF_W-1] ^ d_reg[PAIR_BC[i]][DIFF_W-1];
                side3_reg[i].sig1 <= SIG1_W'(x2_reg[OTH_A[i]]) + SIG1_W'(x2_reg[OTH_B[i]]) +
                                     SIG1_W'(x2_reg[OTH_C[i]]);
                side3_reg[i].sig2 <= SIG2_W'(pp_reg[PAIR_AB[i]]) + SIG2_W'(pp_reg[PAIR_AC[i]]) +
                                     SIG2_W'(pp_reg[PAIR_BC[i]]);
                side3_reg[i].pab  <= pp_reg[PAIR_AB[i]];
                side3_reg[i].xc   <= x2_reg[OTH_C[i]];
            end
            for (int g = 0; g < 3; g++)
            begin
                gm3_reg[g] <= PAIR_W'(mag33(d_reg[2*g])) * PAIR_W'(mag33(d_reg[2*g+1]));
            end
            dneg3_reg <= d_reg[0][DIFF_W-1] ^ d_reg[1][DIFF_W-1] ^ d_reg[2][DIFF_W-1] ^
                         d_reg[3][DIFF_W-1] ^ d_reg[4][DIFF_W-1] ^ d_reg[5][DIFF_W-1];
            eq3_reg   <= eq2_reg;
        end
    end

    // Delay lines matching the multiplier latency
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dl_reg[0] <= side3_reg;
            g2_dl_reg[0]   <= gm3_reg[2];
            eq_dl_reg[0]   <= eq3_reg;
            dneg_dl_reg[0] <= dneg3_reg;
            for (int s = 1; s < MUL_LAT; s++)
            begin
                side_dl_reg[s] <= side_dl_reg[s-1];
                g2_dl_reg[s]   <= g2_dl_reg[s-1];
                eq_dl_reg[s]   <= eq_dl_reg[s-1];
            end
            for (int s = 1; s < 2*MUL_LAT; s++)
            begin
                dneg_dl_reg[s] <= dneg_dl_reg[s-1];
            end
        end
    end

    // w_i = y_i times the product of the other points' differences
    for (genvar i = 0; i < NPT; i++)
    begin : g_w
        cfit_mul u_mul_w (
            .clk (clk),
            .en  (en),
            .a   (MUL_AW'(e3_reg[i])),
            .b   (f3_reg[i]),
            .p   (w_p[i])
        );
        assign pnt[i].w_mag = w_p[i][W_W-1:0];
        assign pnt[i].side  = side_dl_reg[MUL_LAT-1][i];
    end

    // Denominator: product of all six differences
    cfit_mul u_mul_h (
        .clk (clk),
        .en  (en),
        .a   (MUL_AW'(gm3_reg[0])),
        .b   (gm3_reg[1]),
        .p   (h_p)
    );

    cfit_mul u_mul_den (
        .clk (clk),
        .en  (en),
        .a   (MUL_AW'(h_p[2*PAIR_W-1:0])),
        .b   (g2_dl_reg[MUL_LAT-1]),
        .p   (den_p)
    );

    assign sing    = eq_dl_reg[MUL_LAT-1];
    assign den_mag = den_p[DEN_W-1:0];
    assign den_neg = dneg_dl_reg[2*MUL_LAT-1];

endmodule

`default_nettype wire

FILE: rtl/cfit_lane.sv
// One coefficient lane: weighted terms, signed sum, scaling and a bit-per-stage divider.
// Depends on cfit_pkg and cfit_mul. Point data arrives ahead of the denominator, which the lane delays.
`default_nettype none

module cfit_lane
    import cfit_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [1:0]        power,
    input  wire lane_in_t          pnt [NPT],
    input  wire logic [DEN_W-1:0]  den_mag,
    input  wire logic              den_neg,
    output logic      [COEF_W-1:0] coef,
    output logic                   sat
);

    logic signed [TERM_W:0]   term_reg [NPT];
    logic signed [TERM_W+1:0] pair_reg [2];
    logic signed [SUM_W-1:0]  tot_reg;

    logic [DEN_W-1:0] den_dl_reg  [DEN_DLY];
    logic             dneg_dl_reg [DEN_DLY-1];

    logic signed [SUM_W-1:0] tot_abs;
    logic [SHIFT_W-1:0]      sh;
    logic [NUM_W-1:0]        num_reg;
    logic                    nneg_reg;

    logic [REM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] dd_reg  [QUO_W];
    logic [QUO_W-1:0] q_reg   [QUO_W+1];
    logic             neg_reg [QUO_W+1];
    logic             hi_reg  [QUO_W+1];

    logic [COEF_W-1:0] coef_reg;
    logic              sat_reg;
    logic [COEF_W-1:0] coef_next;
    logic              sat_next;

    // Per-point term: w times the lane's symmetric function, signed
    for (genvar i = 0; i < NPT; i++)
    begin : g_term
        logic [MUL_BW-1:0]  b1;
        logic               n1;
        logic [COORD_W-1:0] b2;
        logic               n2;
        logic               tneg;
        logic [COORD_W-1:0] b2_dl_reg   [MUL_LAT];
        logic               tneg_dl_reg [2*MUL_LAT];
        logic [MUL_PW-1:0]  p1;
        logic [MUL_PW-1:0]  p2;

        always_comb
        begin
            logic signed [PAIR_W-1:0] pab_abs;
            logic signed [SIG2_W-1:0] s2_abs;
            logic signed [SIG1_W-1:0] s1_abs;
            pab_abs = pnt[i].side.pab[PAIR_W-1] ? -pnt[i].side.pab : pnt[i].side.pab;
            s2_abs  = pnt[i].side.sig2[SIG2_W-1] ? -pnt[i].side.sig2 : pnt[i].side.sig2;
            s1_abs  = pnt[i].side.sig1[SIG1_W-1] ? -pnt[i].side.sig1 : pnt[i].side.sig1;
            b1 = MUL_BW'(1);
            n1 = 1'b0;
            b2 = COORD_W'(1);
            n2 = 1'b0;
            unique case (power)
                PWR_CONST:
                begin
                    b1 = pab_abs;
                    n1 = pnt[i].side.pab[PAIR_W-1];
                    b2 = mag33(DIFF_W'(pnt[i].side.xc));
                    n2 = pnt[i].side.xc[COORD_W-1];
                end
                PWR_LIN:
                begin
                    b1 = s2_abs[MUL_BW-1:0];
                    n1 = pnt[i].side.sig2[SIG2_W-1];
                end
                PWR_SQR:
                begin
                    b1 = MUL_BW'(s1_abs);
                    n1 = pnt[i].side.sig1[SIG1_W-1];
                end
                PWR_CUBE:
                begin
                    b1 = MUL_BW'(1);
                end
                default:
                begin
                    b1 = MUL_BW'(1);
                end
            endcase
            // alternating sign of the Lagrange expansion
            tneg = pnt[i].side.wneg ^ n1 ^ n2 ^ 1'(i % 2) ^ ~power[0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                b2_dl_reg[0]   <= b2;
                tneg_dl_reg[0] <= tneg;
                for (int s = 1; s < MUL_LAT; s++)
                begin
                    b2_dl_reg[s] <= b2_dl_reg[s-1];
                end
                for (int s = 1; s < 2*MUL_LAT; s++)
                begin
                    tneg_dl_reg[s] <= tneg_dl_reg[s-1];
                end
                term_reg[i] <= tneg_dl_reg[2*MUL_LAT-1] ?
                               -$signed({1'b0, p2[TERM_W-1:0]}) :
                                $signed({1'b0, p2[TERM_W-1:0]});
            end
        end

        cfit_mul u_mul_1 (
            .clk (clk),
            .en  (en),
            .a   (MUL_AW'(pnt[i].w_mag)),
            .b   (b1),
            .p   (p1)
        );

        cfit_mul u_mul_2 (
            .clk (clk),
            .en  (en),
            .a   (p1[MUL_AW-1:0]),
            .b   (MUL_BW'(b2_dl_reg[MUL_LAT-1])),
            .p   (p2)
        );
    end

    // Sum tree, magnitude and scaling to 16 + 16 * power fraction bits (Q32.32 for the linear lane)
    always_comb
    begin
        tot_abs = tot_reg[SUM_W-1] ? -tot_reg : tot_reg;
        sh      = SHIFT_W'({power, 4'b0000}) + SHIFT_W'(Q_SHIFT_BASE);
    end

    // Denominator sign is taken one stage before its magnitude
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair_reg[0] <= (TERM_W+2)'(term_reg[0]) + (TERM_W+2)'(term_reg[1]);
            pair_reg[1] <= (TERM_W+2)'(term_reg[2]) + (TERM_W+2)'(term_reg[3]);
            tot_reg     <= SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
            num_reg     <= NUM_W'(tot_abs[SUM_W-2:0]) << sh;
            nneg_reg    <= tot_reg[SUM_W-1] ^ dneg_dl_reg[DEN_DLY-2];
            den_dl_reg[0]  <= den_mag;
            dneg_dl_reg[0] <= den_neg;
            for (int s = 1; s < DEN_DLY; s++)
            begin
                den_dl_reg[s] <= den_dl_reg[s-1];
            end
            for (int s = 1; s < DEN_DLY-1; s++)
            begin
                dneg_dl_reg[s] <= dneg_dl_reg[s-1];
            end
        end
    end

    // Divider entry: quotient of 2^65 or more cannot fit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg[0]  <= num_reg >= NUM_W'({den_dl_reg[DEN_DLY-1], QUO_W'(0)});
            rem_reg[0] <= num_reg[REM_W-1:0];
            dd_reg[0]  <= den_dl_reg[DEN_DLY-1];
            neg_reg[0] <= nneg_reg;
            q_reg[0]   <= '0;
        end
    end

    // Restoring division, one quotient bit per stage, MSB first
    for (genvar s = 0; s < QUO_W; s++)
    begin : g_div
        localparam int BIT = QUO_W - 1 - s;
        logic [REM_W-1:0] dsh;
        logic [REM_W:0]   trial;

        assign dsh   = REM_W'(dd_reg[s]) << BIT;
        assign trial = {1'b0, rem_reg[s]} - {1'b0, dsh};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[s+1]   <= trial[REM_W] ? q_reg[s] : (q_reg[s] | (QUO_W'(1) << BIT));
                neg_reg[s+1] <= neg_reg[s];
                hi_reg[s+1]  <= hi_reg[s];
            end
        end

        if (s < QUO_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s+1] <= trial[REM_W] ? rem_reg[s] : trial[REM_W-1:0];
                    dd_reg[s+1]  <= dd_reg[s];
                end
            end
        end
    end

    // Sign and saturation
    always_comb
    begin
        logic [QUO_W-1:0] q;
        q = q_reg[QUO_W];
        sat_next  = 1'b0;
        coef_next = q[COEF_W-1:0];
        if (!neg_reg[QUO_W])
        begin
            if (hi_reg[QUO_W] || q[QUO_W-1] || q[COEF_W-1])
            begin
                sat_next  = 1'b1;
                coef_next = COEF_MAX;
            end
        end
        else
        begin
            if (hi_reg[QUO_W] || q[QUO_W-1] || (q[COEF_W-1] && (|q[COEF_W-2:0])))
            begin
                sat_next  = 1'b1;
                coef_next = COEF_MIN;
            end
            else
            begin
                coef_next = -q[COEF_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg <= coef_next;
            sat_reg  <= sat_next;
        end
    end

    assign coef = coef_reg;
    assign sat  = sat_reg;

endmodule

`default_nettype wire

FILE: rtl/cubic_fit_four_points.sv
// Top level of the cubic fit: input stream, shared front end, four coefficient lanes, merge.
// Depends on cfit_pkg, cfit_front, cfit_lane (and through them cfit_mul).
//
//  channel  | dir | payload
//  ---------+-----+-------------------------------------------------------------
//  s_axis   | in  | tdata: point0_x .. point3_y, 32 bits each, x before y
//  m_axis   | out | tdata: coef_cubic .. coef_constant, 64 bits each; tuser: fit_status
//
// One item per cycle sustained while results are taken; each item passes through 83 pipeline
// registers, dominated by the 65 one-bit stages of each lane's divider, and then the output
// register. No clearing after reset; the block takes items at once.
// The pipeline holds only while its last stage has a result and the output register
// is occupied and not being taken; every stage and the input then hold.
`default_nettype none

module cubic_fit_four_points
    import cfit_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_W-1:0]   s_axis_tdata,   // point0_x, point0_y, ... point3_x, point3_y
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [OUT_W-1:0]  m_axis_tdata,   // coef_cubic, coef_square, coef_linear,
                                                   // coef_constant
    output logic      [STAT_W-1:0] m_axis_tuser    // fit_status
);

    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [LANE_DEPTH-1:0] sing_dl_reg;

    lane_in_t          pnt [NPT];
    logic              sing;
    logic [DEN_W-1:0]  den_mag;
    logic              den_neg;
    logic [COEF_W-1:0] coef [NPT];
    logic [NPT-1:0]    sat;

    logic              out_vld_reg;
    logic [OUT_W-1:0]  data_reg;
    fit_status_t       user_reg;
    logic [OUT_W-1:0]  data_next;
    fit_status_t       user_next;

    // Global advance
    assign en            = !vld_reg[PIPE_DEPTH-1] || !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_dl_reg <= {sing_dl_reg[LANE_DEPTH-2:0], sing};
        end
    end

    cfit_front u_front (
        .clk     (clk),
        .en      (en),
        .pts     (s_axis_tdata),
        .pnt     (pnt),
        .sing    (sing),
        .den_mag (den_mag),
        .den_neg (den_neg)
    );

    // Lane k produces the coefficient of x^k
    for (genvar k = 0; k < NPT; k++)
    begin : g_lane
        cfit_lane u_lane (
            .clk     (clk),
            .en      (en),
            .power   (2'(k)),
            .pnt     (pnt),
            .den_mag (den_mag),
            .den_neg (den_neg),
            .coef    (coef[k]),
            .sat     (sat[k])
        );
    end

    // Merge lanes into one result item
    always_comb
    begin
        data_next = '0;
        for (int k = 0; k < NPT; k++)
        begin
            data_next[(NPT-1-k)*COEF_W +: COEF_W] = coef[k];
        end
        if (sing_dl_reg[LANE_DEPTH-1])
        begin
            data_next = '0;
            user_next = FIT_SINGULAR;
        end
        else if (|sat)
        begin
            user_next = FIT_SATURATED;
        end
        else
        begin
            user_next = FIT_OK;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en && vld_reg[PIPE_DEPTH-1])
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[PIPE_DEPTH-1])
        begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;

endmodule

`default_nettype wire

FILE: rtl/cfit_checker.sv
// Port-level checks for the cubic fit top level, attached by bind.
// Depends on cfit_pkg and the top level cubic_fit_four_points.
`default_nettype none

module cfit_checker
    import cfit_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic [IN_W-1:0]   s_axis_tdata,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [OUT_W-1:0]  m_axis_tdata,
    input wire logic [STAT_W-1:0] m_axis_tuser
);

    // A singular item carries all-zero coefficients
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == FIT_SINGULAR) |-> (m_axis_tdata == '0))
        else $error("singular item with nonzero coefficients");

    // With no result waiting, the input side is open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // Valid drops only after a handshake
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("output valid withdrawn");

endmodule

bind cubic_fit_four_points cfit_checker u_cfit_checker (.*);

`default_nettype wire
